// ===== src/gfr_pkg.sv =====
// ----------------------------------------------------------------------------
// gfr_pkg: shared types and constants of the grid field-of-view raycaster
// Command codes, field widths, default map size and the control groups that
// pass between the sequencer, the ray step unit and the cell memory.
// ----------------------------------------------------------------------------
package gfr_pkg;

	localparam int X_W        = 6;
	localparam int Y_W        = 5;
	localparam int RAD_W      = 4;
	localparam int DELTA_W    = RAD_W + 1;
	localparam int ERR_W      = RAD_W + 3;
	localparam int IN_DATA_W  = 16;
	localparam int OUT_DATA_W = 8;

	localparam int DEF_MAP_COLS = 64;
	localparam int DEF_MAP_ROWS = 32;

	localparam logic [RAD_W-1:0] RAD_RESET = 4'd8;

	typedef enum logic [1:0] {
		CMD_WRITE = 2'd0,
		CMD_VIEW  = 2'd1,
		CMD_READ  = 2'd2,
		CMD_WIPE  = 2'd3
	} gfr_cmd_t;

	typedef enum logic {
		KIND_CELL = 1'b0,
		KIND_DONE = 1'b1
	} gfr_kind_t;

	typedef struct packed {
		logic wr_solid;
		logic solid_val;
		logic mark;
		logic clr_vis;
		logic clr_all;
	} gfr_mem_op_t;

	typedef struct packed {
		logic on_map;
		logic at_target;
	} gfr_ray_stat_t;

endpackage

// ===== src/gfr_cell_mem.sv =====
// ----------------------------------------------------------------------------
// gfr_cell_mem: row-wide storage of the solid, visible and explored bits
// One row address per cycle; single-cell writes, whole-row clears and a
// registered read of the addressed cell.
// ----------------------------------------------------------------------------
module gfr_cell_mem #(
	parameter int MAP_COLS = gfr_pkg::DEF_MAP_COLS,
	parameter int MAP_ROWS = gfr_pkg::DEF_MAP_ROWS
) (
	input  logic                        clk,
	input  logic [$clog2(MAP_ROWS)-1:0] row,
	input  logic [$clog2(MAP_COLS)-1:0] col,
	input  gfr_pkg::gfr_mem_op_t        op,
	output logic                        rd_solid_q,
	output logic                        rd_visible_q,
	output logic                        rd_explored_q
);
	import gfr_pkg::*;

	logic [MAP_COLS-1:0] solid_mem    [MAP_ROWS];
	logic [MAP_COLS-1:0] visible_mem  [MAP_ROWS];
	logic [MAP_COLS-1:0] explored_mem [MAP_ROWS];

	always_ff @(posedge clk) begin
		if (op.clr_all) begin
			solid_mem[row]    <= '1;
			visible_mem[row]  <= '0;
			explored_mem[row] <= '0;
		end else begin
			if (op.clr_vis) begin
				visible_mem[row] <= '0;
			end
			if (op.wr_solid) begin
				solid_mem[row][col] <= op.solid_val;
			end
			if (op.mark) begin
				visible_mem[row][col]  <= 1'b1;
				explored_mem[row][col] <= 1'b1;
			end
		end
		rd_solid_q    <= solid_mem[row][col];
		rd_visible_q  <= visible_mem[row][col];
		rd_explored_q <= explored_mem[row][col];
	end

endmodule

// ===== src/gfr_ray_step.sv =====
// ----------------------------------------------------------------------------
// gfr_ray_step: shared Bresenham step and cell test
// Gives the next ray position and error term, whether the current position
// lies on the map and whether it is the ray's target.
// ----------------------------------------------------------------------------
module gfr_ray_step #(
	parameter int MAP_COLS = gfr_pkg::DEF_MAP_COLS,
	parameter int MAP_ROWS = gfr_pkg::DEF_MAP_ROWS,
	parameter int CW       = 8
) (
	input  logic signed [CW-1:0]            x,
	input  logic signed [CW-1:0]            y,
	input  logic signed [CW-1:0]            tx,
	input  logic signed [CW-1:0]            ty,
	input  logic signed [gfr_pkg::ERR_W-1:0] err,
	input  logic [gfr_pkg::RAD_W-1:0]        run,
	input  logic [gfr_pkg::RAD_W-1:0]        rise_mag,
	input  logic                             neg_x,
	input  logic                             neg_y,
	output logic signed [CW-1:0]            x_nxt,
	output logic signed [CW-1:0]            y_nxt,
	output logic signed [gfr_pkg::ERR_W-1:0] err_nxt,
	output gfr_pkg::gfr_ray_stat_t           stat
);
	import gfr_pkg::*;

	localparam logic signed [CW-1:0] ONE   = CW'(1);
	localparam logic signed [CW-1:0] COLS  = CW'(MAP_COLS);
	localparam logic signed [CW-1:0] ROWS  = CW'(MAP_ROWS);

	logic signed [ERR_W:0] twice;
	logic signed [ERR_W:0] run_s;
	logic signed [ERR_W:0] rise_s;
	logic signed [ERR_W:0] err_s;
	logic signed [ERR_W:0] err_sum;
	logic                  step_x;
	logic                  step_y;

	always_comb begin
		twice   = $signed({err, 1'b0});
		run_s   = $signed({{(ERR_W + 1 - RAD_W){1'b0}}, run});
		rise_s  = -$signed({{(ERR_W + 1 - RAD_W){1'b0}}, rise_mag});
		err_s   = $signed({err[ERR_W-1], err});
		step_x  = (twice >= rise_s);
		step_y  = (twice <= run_s);
		err_sum = err_s + (step_x ? rise_s : '0) + (step_y ? run_s : '0);
		err_nxt = err_sum[ERR_W-1:0];
		x_nxt   = step_x ? (neg_x ? x - ONE : x + ONE) : x;
		y_nxt   = step_y ? (neg_y ? y - ONE : y + ONE) : y;

		stat.on_map    = !x[CW-1] && !y[CW-1] && (x < COLS) && (y < ROWS);
		stat.at_target = (x == tx) && (y == ty);
	end

endmodule

// ===== src/grid_fov_raycaster.sv =====
// ----------------------------------------------------------------------------
// grid_fov_raycaster: tile grid with Bresenham field-of-view computation
// Keeps solid, visible and explored bits per cell and serves write, view,
// read and wipe commands one at a time under a small sequencer.
// ----------------------------------------------------------------------------
// After reset the block wipes the map (every cell a wall, nothing visible or
// explored) row by row and takes no transaction until that is done.
// One command is handled at a time; s_tready is high only while idle. A
// solid-bit write is done in S_WR; a cell read addresses the cell memory
// (S_RD_ADDR), then loads the registered cell bits into the output register
// (S_RD_RESP), waiting while that register is full; a wipe sweeps every row.
// A view computation clears the visible bits row by row, then scans (2r+1)^2
// candidate targets, and every ray walks its cells in turn, each cell being
// looked up in the cell memory and then marked. The result (cell bits, or a
// done marker) sits in an output register, and the next command is taken
// while it waits there.
// ----------------------------------------------------------------------------
module grid_fov_raycaster #(
	parameter int MAP_COLS = gfr_pkg::DEF_MAP_COLS,
	parameter int MAP_ROWS = gfr_pkg::DEF_MAP_ROWS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [gfr_pkg::RAD_W-1:0]         cfg_wr_data,   // view radius
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [gfr_pkg::IN_DATA_W-1:0]     s_tdata,       // cell_x, cell_y, solid_in
	input  logic [1:0]                        s_tuser,       // cmd
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [gfr_pkg::OUT_DATA_W-1:0]    m_tdata,       // cell_visible, cell_explored,
	                                                         // cell_solid
	output logic                              m_tuser        // result_kind
);
	import gfr_pkg::*;

	localparam int XSPAN = ((MAP_COLS > (2 ** X_W)) ? MAP_COLS : (2 ** X_W)) + 16;
	localparam int YSPAN = ((MAP_ROWS > (2 ** Y_W)) ? MAP_ROWS : (2 ** Y_W)) + 16;
	localparam int CW    = $clog2((XSPAN > YSPAN) ? XSPAN : YSPAN) + 1;
	localparam int RW    = $clog2(MAP_ROWS);
	localparam int CLW   = $clog2(MAP_COLS);
	localparam logic [RW-1:0] LAST_ROW = RW'(MAP_ROWS - 1);

	typedef enum logic [3:0] {
		S_WIPE,
		S_IDLE,
		S_WR,
		S_RD_ADDR,
		S_RD_RESP,
		S_VCLR,
		S_SCAN,
		S_LOOK,
		S_MARK,
		S_DONE
	} state_t;

	state_t                    state_q;
	logic [RAD_W-1:0]          rad_q;
	logic [RW-1:0]             sweep_q;
	logic signed [CW-1:0]      ox_q, oy_q;
	logic signed [CW-1:0]      cur_x_q, cur_y_q;
	logic signed [CW-1:0]      tx_q, ty_q;
	logic signed [DELTA_W-1:0] dx_q, dy_q;
	logic signed [ERR_W-1:0]   err_q;
	logic [RAD_W-1:0]          run_q, rise_q;
	logic                      negx_q, negy_q;
	logic                      solid_q;
	logic                      m_tvalid_q;
	logic                      kind_q;
	logic [2:0]                bits_q;

	logic [X_W-1:0]            in_x;
	logic [Y_W-1:0]            in_y;
	logic                      in_solid;
	logic                      accept;
	logic                      out_free;
	logic                      res_load;

	logic signed [CW-1:0]      x_nxt, y_nxt;
	logic signed [ERR_W-1:0]   err_nxt;
	gfr_ray_stat_t             stat;

	gfr_mem_op_t               op;
	logic [RW-1:0]             mem_row;
	logic [CLW-1:0]            mem_col;
	logic                      rd_solid, rd_visible, rd_explored;

	logic signed [DELTA_W-1:0] r_s;
	logic signed [2*DELTA_W-1:0] dx2, dy2;
	logic [RAD_W*2-1:0]        r2;
	logic [RAD_W*2:0]          sumsq;
	logic                      in_circle;
	logic                      last_tgt;
	logic [DELTA_W-1:0]        adx, ady;
	logic signed [CW-1:0]      tx_new, ty_new;

	assign in_x     = s_tdata[X_W-1:0];
	assign in_y     = s_tdata[X_W+Y_W-1:X_W];
	assign in_solid = s_tdata[X_W+Y_W];
	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign res_load = out_free && ((state_q == S_RD_RESP) || (state_q == S_DONE));

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = kind_q;
	assign m_tdata  = {{(OUT_DATA_W - 3){1'b0}}, bits_q};

	always_comb begin
		r_s       = $signed({1'b0, rad_q});
		dx2       = dx_q * dx_q;
		dy2       = dy_q * dy_q;
		r2        = rad_q * rad_q;
		sumsq     = {1'b0, dx2[RAD_W*2-1:0]} + {1'b0, dy2[RAD_W*2-1:0]};
		in_circle = (sumsq <= {1'b0, r2});
		last_tgt  = (dx_q == r_s) && (dy_q == r_s);
		adx       = dx_q[DELTA_W-1] ? -dx_q : dx_q;
		ady       = dy_q[DELTA_W-1] ? -dy_q : dy_q;
		tx_new    = ox_q + $signed({{(CW - DELTA_W){dx_q[DELTA_W-1]}}, dx_q});
		ty_new    = oy_q + $signed({{(CW - DELTA_W){dy_q[DELTA_W-1]}}, dy_q});
	end

	gfr_ray_step #(
		.MAP_COLS (MAP_COLS),
		.MAP_ROWS (MAP_ROWS),
		.CW       (CW)
	) u_step (
		.x        (cur_x_q),
		.y        (cur_y_q),
		.tx       (tx_q),
		.ty       (ty_q),
		.err      (err_q),
		.run      (run_q),
		.rise_mag (rise_q),
		.neg_x    (negx_q),
		.neg_y    (negy_q),
		.x_nxt    (x_nxt),
		.y_nxt    (y_nxt),
		.err_nxt  (err_nxt),
		.stat     (stat)
	);

	always_comb begin
		op      = '0;
		mem_row = cur_y_q[RW-1:0];
		mem_col = cur_x_q[CLW-1:0];
		unique case (state_q)
			S_WIPE: begin
				mem_row    = sweep_q;
				op.clr_all = 1'b1;
			end
			S_VCLR: begin
				mem_row    = sweep_q;
				op.clr_vis = 1'b1;
			end
			S_WR: begin
				op.wr_solid  = stat.on_map;
				op.solid_val = solid_q;
			end
			S_MARK: begin
				op.mark = 1'b1;
			end
			default: begin
				op = '0;
			end
		endcase
	end

	gfr_cell_mem #(
		.MAP_COLS (MAP_COLS),
		.MAP_ROWS (MAP_ROWS)
	) u_mem (
		.clk           (clk),
		.row           (mem_row),
		.col           (mem_col),
		.op            (op),
		.rd_solid_q    (rd_solid),
		.rd_visible_q  (rd_visible),
		.rd_explored_q (rd_explored)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_WIPE;
			sweep_q    <= '0;
			rad_q      <= RAD_RESET;
			m_tvalid_q <= 1'b0;
			kind_q     <= KIND_CELL;
			bits_q     <= '0;
			ox_q       <= '0;
			oy_q       <= '0;
			cur_x_q    <= '0;
			cur_y_q    <= '0;
			tx_q       <= '0;
			ty_q       <= '0;
			dx_q       <= '0;
			dy_q       <= '0;
			err_q      <= '0;
			run_q      <= '0;
			rise_q     <= '0;
			negx_q     <= 1'b0;
			negy_q     <= 1'b0;
			solid_q    <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				rad_q <= cfg_wr_data;
			end
			if (res_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end

			unique case (state_q)
				S_WIPE, S_VCLR: begin
					if (sweep_q == LAST_ROW) begin
						sweep_q <= '0;
						if (state_q == S_VCLR) begin
							dx_q    <= -r_s;
							dy_q    <= -r_s;
							state_q <= S_SCAN;
						end else begin
							state_q <= S_IDLE;
						end
					end else begin
						sweep_q <= sweep_q + RW'(1);
					end
				end
				S_IDLE: begin
					if (accept) begin
						cur_x_q <= $signed(CW'({1'b0, in_x}));
						cur_y_q <= $signed(CW'({1'b0, in_y}));
						ox_q    <= $signed(CW'({1'b0, in_x}));
						oy_q    <= $signed(CW'({1'b0, in_y}));
						solid_q <= in_solid;
						unique case (gfr_cmd_t'(s_tuser))
							CMD_WRITE: state_q <= S_WR;
							CMD_VIEW:  state_q <= S_VCLR;
							CMD_READ:  state_q <= S_RD_ADDR;
							CMD_WIPE:  state_q <= S_WIPE;
							default:   state_q <= S_IDLE;
						endcase
					end
				end
				S_WR: begin
					state_q <= S_IDLE;
				end
				S_RD_ADDR: begin
					state_q <= S_RD_RESP;
				end
				S_RD_RESP: begin
					if (out_free) begin
						kind_q     <= KIND_CELL;
						bits_q     <= stat.on_map ? {rd_solid, rd_explored, rd_visible} : 3'b000;
						state_q    <= S_IDLE;
					end
				end
				S_SCAN: begin
					if (in_circle) begin
						cur_x_q <= ox_q;
						cur_y_q <= oy_q;
						tx_q    <= tx_new;
						ty_q    <= ty_new;
						run_q   <= adx[RAD_W-1:0];
						rise_q  <= ady[RAD_W-1:0];
						err_q   <= $signed({{(ERR_W - DELTA_W){1'b0}}, adx})
						         - $signed({{(ERR_W - DELTA_W){1'b0}}, ady});
						negx_q  <= !(dx_q > 0);
						negy_q  <= !(dy_q > 0);
						state_q <= S_LOOK;
					end else if (last_tgt) begin
						state_q <= S_DONE;
					end else begin
						if (dx_q == r_s) begin
							dx_q <= -r_s;
							dy_q <= dy_q + DELTA_W'(1);
						end else begin
							dx_q <= dx_q + DELTA_W'(1);
						end
					end
				end
				S_LOOK, S_MARK: begin
					if ((state_q == S_LOOK && !stat.on_map)
					    || (state_q == S_MARK && (rd_solid || stat.at_target))) begin
						if (last_tgt) begin
							state_q <= S_DONE;
						end else begin
							state_q <= S_SCAN;
							if (dx_q == r_s) begin
								dx_q <= -r_s;
								dy_q <= dy_q + DELTA_W'(1);
							end else begin
								dx_q <= dx_q + DELTA_W'(1);
							end
						end
					end else if (state_q == S_LOOK) begin
						state_q <= S_MARK;
					end else begin
						cur_x_q <= x_nxt;
						cur_y_q <= y_nxt;
						err_q   <= err_nxt;
						state_q <= S_LOOK;
					end
				end
				S_DONE: begin
					if (out_free) begin
						kind_q     <= KIND_DONE;
						bits_q     <= 3'b000;
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== tb/grid_fov_raycaster_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// grid_fov_raycaster_tb: self-checking bench for the grid field-of-view block
// Drives write, view, read and wipe commands over the input stream, keeps its
// own copy of the solid, visible and explored maps, replays every accepted
// command on that copy (Bresenham rays included) and compares each output
// transaction field by field with the oldest predicted answer. Directed tests
// cover the reset contents, map corners, radius extremes and the wipe; random
// phases open small rooms, look around from inside them and read back cells,
// mixed with unrelated commands, mostly under random idling on both streams.
// ----------------------------------------------------------------------------
module grid_fov_raycaster_tb;

	import gfr_pkg::*;

	localparam int COLS        = DEF_MAP_COLS;
	localparam int ROWS        = DEF_MAP_ROWS;
	localparam int SETTLE      = ROWS + 8;
	localparam int CYCLE_LIMIT = 2_000_000;

	typedef struct packed {
		gfr_kind_t kind;
		logic      visible;
		logic      explored;
		logic      solid;
	} cell_answer_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_wr_en;
	logic [RAD_W-1:0]      cfg_wr_data;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata;
	logic [1:0]            s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  m_tuser;

	bit           solid_bits    [COLS*ROWS];
	bit           visible_bits  [COLS*ROWS];
	bit           explored_bits [COLS*ROWS];
	int           view_radius;
	cell_answer_t cell_answers[$];
	int           err_count;
	int           cycle_count = 0;
	bit           no_idle;

	grid_fov_raycaster dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("grid_fov_raycaster: mismatch");
			$finish;
		end
	end

	function automatic void reset_maps();
		for (int i = 0; i < COLS*ROWS; i++) begin
			solid_bits[i]    = 1'b1;
			visible_bits[i]  = 1'b0;
			explored_bits[i] = 1'b0;
		end
	endfunction

	function automatic void cast_ray(int ox, int oy, int tx, int ty);
		int x, y, run, rise, sx, sy, err, twice, at;
		bit going;
		x     = ox;
		y     = oy;
		run   = (tx > ox) ? tx - ox : ox - tx;
		rise  = (ty > oy) ? oy - ty : ty - oy;
		sx    = (ox < tx) ? 1 : -1;
		sy    = (oy < ty) ? 1 : -1;
		err   = run + rise;
		going = 1'b1;
		while (going && x >= 0 && x < COLS && y >= 0 && y < ROWS) begin
			at = y * COLS + x;
			visible_bits[at]  = 1'b1;
			explored_bits[at] = 1'b1;
			if (solid_bits[at] || (x == tx && y == ty)) begin
				going = 1'b0;
			end else begin
				twice = 2 * err;
				if (twice >= rise) begin
					err += rise;
					x   += sx;
				end
				if (twice <= run) begin
					err += run;
					y   += sy;
				end
			end
		end
	endfunction

	function automatic void sweep_view(int ox, int oy);
		for (int i = 0; i < COLS*ROWS; i++)
			visible_bits[i] = 1'b0;
		for (int dy = -view_radius; dy <= view_radius; dy++)
			for (int dx = -view_radius; dx <= view_radius; dx++)
				if (dx*dx + dy*dy <= view_radius*view_radius)
					cast_ray(ox, oy, ox + dx, oy + dy);
	endfunction

	function automatic void apply_command(gfr_cmd_t cmd, int x, int y, bit solid);
		cell_answer_t ans;
		int at;
		at = y * COLS + x;
		case (cmd)
			CMD_WRITE: begin
				solid_bits[at] = solid;
			end
			CMD_VIEW: begin
				sweep_view(x, y);
				ans = '{kind: KIND_DONE, visible: 1'b0, explored: 1'b0, solid: 1'b0};
				cell_answers = {cell_answers, ans};
			end
			CMD_READ: begin
				ans = '{kind: KIND_CELL, visible: visible_bits[at],
					explored: explored_bits[at], solid: solid_bits[at]};
				cell_answers = {cell_answers, ans};
			end
			default: begin
				reset_maps();
			end
		endcase
	endfunction

	function automatic int near(int c, int span, int hi);
		int v;
		v = c + $urandom_range(0, 2*span) - span;
		if (v < 0)
			v = 0;
		if (v > hi)
			v = hi;
		return v;
	endfunction

	task automatic report_mismatch(string field, int got, int want);
		$display("[%0t] %s: got %0d, expected %0d", $realtime, field, got, want);
		err_count++;
	endtask

	task automatic check_answer();
		cell_answer_t want;
		if (cell_answers.size() == 0) begin
			report_mismatch("unexpected result, kind", m_tuser, -1);
		end else begin
			want = cell_answers.pop_front();
			if (m_tuser !== want.kind)
				report_mismatch("result_kind", m_tuser, want.kind);
			if (m_tdata[0] !== want.visible)
				report_mismatch("cell_visible", m_tdata[0], want.visible);
			if (m_tdata[1] !== want.explored)
				report_mismatch("cell_explored", m_tdata[1], want.explored);
			if (m_tdata[2] !== want.solid)
				report_mismatch("cell_solid", m_tdata[2], want.solid);
		end
	endtask

	initial begin : result_sink
		int stall;
		m_tready = 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			stall = no_idle ? 0 : $urandom_range(0, 16);
			if (stall != 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid)
				@(posedge clk);
			check_answer();
		end
	end

	task automatic send_cmd(gfr_cmd_t cmd, int x, int y, int solid);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 16);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= {4'b0, solid[0], y[4:0], x[5:0]};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		apply_command(cmd, x[5:0], y[4:0], solid[0]);
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (cell_answers.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_radius(int rad);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= rad[RAD_W-1:0];
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
		view_radius = rad;
	endtask

	task automatic test_reset_contents();
		send_cmd(CMD_READ, 0, 0, 0);
		send_cmd(CMD_READ, 63, 31, 1);
	endtask

	// corner origin at the reset radius: rays leave the map, wall behind stops
	task automatic test_corner_view();
		send_cmd(CMD_WRITE, 63, 31, 0);
		send_cmd(CMD_WRITE, 62, 31, 0);
		send_cmd(CMD_WRITE, 63, 30, 0);
		send_cmd(CMD_VIEW, 63, 31, 1);
		send_cmd(CMD_READ, 63, 31, 0);
		send_cmd(CMD_READ, 61, 31, 0);
		send_cmd(CMD_READ, 60, 31, 0);
		send_cmd(CMD_READ, 63, 29, 0);
	endtask

	task automatic test_radius_zero();
		drain_results();
		set_radius(0);
		send_cmd(CMD_VIEW, 62, 31, 0);
		send_cmd(CMD_READ, 63, 31, 0);
		send_cmd(CMD_READ, 62, 31, 0);
	endtask

	task automatic test_wide_radius();
		drain_results();
		set_radius(15);
		send_cmd(CMD_WRITE, 32, 16, 0);
		send_cmd(CMD_WRITE, 33, 16, 0);
		send_cmd(CMD_WRITE, 31, 17, 0);
		send_cmd(CMD_VIEW, 32, 16, 0);
		send_cmd(CMD_READ, 34, 16, 0);
		send_cmd(CMD_READ, 30, 18, 0);
	endtask

	task automatic test_wipe();
		send_cmd(CMD_WIPE, 17, 9, 1);
		send_cmd(CMD_READ, 63, 31, 0);
		send_cmd(CMD_READ, 32, 16, 0);
	endtask

	task automatic test_small_radius_origin();
		drain_results();
		set_radius(1);
		send_cmd(CMD_WRITE, 0, 0, 0);
		send_cmd(CMD_WRITE, 1, 0, 0);
		send_cmd(CMD_VIEW, 0, 0, 0);
		send_cmd(CMD_READ, 1, 1, 0);
		send_cmd(CMD_READ, 2, 0, 0);
	endtask

	// open a small room, look around from inside it, read back nearby cells
	task automatic test_random_phase(int rad, int count, bit burst);
		int sent, k, j, cx, cy;
		drain_results();
		set_radius(rad);
		no_idle = burst;
		sent = 0;
		while (sent < count) begin
			if ($urandom_range(0, 4) == 0) begin
				send_cmd(gfr_cmd_t'($urandom_range(0, 3)), $urandom_range(0, 63),
					$urandom_range(0, 31), $urandom_range(0, 1));
				sent++;
			end else begin
				cx = ($urandom_range(0, 3) == 0) ? 63 * $urandom_range(0, 1)
					: $urandom_range(0, 63);
				cy = ($urandom_range(0, 3) == 0) ? 31 * $urandom_range(0, 1)
					: $urandom_range(0, 31);
				k  = $urandom_range(2, 8);
				j  = $urandom_range(2, 5);
				send_cmd(CMD_WRITE, cx, cy, 0);
				repeat (k)
					send_cmd(CMD_WRITE, near(cx, 3, 63), near(cy, 3, 31),
						$urandom_range(0, 3) == 0);
				send_cmd(CMD_VIEW, cx, cy, $urandom_range(0, 1));
				repeat (j)
					send_cmd(CMD_READ, near(cx, rad + 1, 63), near(cy, rad + 1, 31),
						$urandom_range(0, 1));
				sent += k + j + 2;
			end
		end
		no_idle = 1'b0;
	endtask

	initial begin
		arst_n      = 1'b0;
		cfg_wr_en   = 1'b0;
		cfg_wr_data = '0;
		s_tvalid    = 1'b0;
		s_tdata     = '0;
		s_tuser     = CMD_WRITE;
		err_count   = 0;
		no_idle     = 1'b0;
		view_radius = RAD_RESET;
		reset_maps();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_contents();
		test_corner_view();
		test_radius_zero();
		test_wide_radius();
		test_wipe();
		test_small_radius_origin();

		test_random_phase(3, 28, 1'b0);
		test_random_phase(1, 28, 1'b0);
		test_random_phase(5, 28, 1'b1);
		test_random_phase(8, 28, 1'b0);
		test_random_phase(15, 24, 1'b0);
		test_random_phase(2, 28, 1'b0);
		test_random_phase($urandom_range(1, 7), 30, 1'b0);

		drain_results();
		if (err_count == 0)
			$display("grid_fov_raycaster: match");
		else
			$display("grid_fov_raycaster: mismatch");
		$finish;
	end

endmodule
